>>> sv/hti_pkg.sv
// shared types and constants for the heightfield triangle interpolator
// depends on nothing; imported by every module of the block except hti_ram
package hti_pkg;

  localparam int GRID_MAX = 256;
  localparam int GRID_AW  = $clog2(GRID_MAX);
  localparam int STORE_AW = 2 * GRID_AW;
  localparam int ABS_W    = 33;
  localparam int MAG_W    = 41;
  localparam int DIV_W    = MAG_W + 16;
  localparam int HI_W     = DIV_W - 16;
  localparam int CDIV_W   = 47;
  // fold stages that bring a CDIV_W-bit value below two times 255
  localparam int CDIV_STAGES = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [8:0] HEIGHT_DENOM = 9'd255;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    REG_GRID_COLUMNS = 3'd0,
    REG_GRID_ROWS    = 3'd1,
    REG_ORIGIN_X     = 3'd2,
    REG_ORIGIN_Y     = 3'd3,
    REG_ORIGIN_Z     = 3'd4,
    REG_SCALE_X      = 3'd5,
    REG_SCALE_Y      = 3'd6,
    REG_SCALE_Z      = 3'd7
  } cfg_reg_e;

  // configuration as the datapath sees it: clamped and guarded
  typedef struct packed {
    logic [8:0]         cols;
    logic [8:0]         rows;
    logic [7:0]         gx;
    logic [7:0]         gz;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] scale_y;
    logic [30:0]        div_x;
    logic [30:0]        div_z;
  } cfg_t;

  // one classified item between front and back
  typedef struct packed {
    logic             mode;
    logic [7:0]       column;
    logic [7:0]       row;
    logic [7:0]       sample;
    logic             sx;
    logic [MAG_W-1:0] magx;
    logic             sz;
    logic [MAG_W-1:0] magz;
  } item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> sv/hti_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module hti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/hti_front.sv
// front stage: accepts input beats, offsets the query point and scales by grid size
// depends on hti_pkg
module hti_front import hti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               mode,
  input  logic [7:0]         column,
  input  logic [7:0]         row,
  input  logic [7:0]         height_sample,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_z,
  input  logic               queue_full,
  output logic               front_valid,
  output item_t              front_item
);

  logic             f_mode;
  logic [7:0]       f_column;
  logic [7:0]       f_row;
  logic [7:0]       f_sample;
  logic             f_sx;
  logic             f_sz;
  logic [ABS_W-1:0] f_absx;
  logic [ABS_W-1:0] f_absz;

  logic signed [ABS_W-1:0] diff_x;
  logic signed [ABS_W-1:0] diff_z;
  logic                    accept;

  assign item_ready = !front_valid || !queue_full;
  assign accept     = item_valid && item_ready;

  assign diff_x = ABS_W'(query_x) - ABS_W'(cfg.origin_x);
  assign diff_z = ABS_W'(query_z) - ABS_W'(cfg.origin_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (!queue_full) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_mode   <= mode;
      f_column <= column;
      f_row    <= row;
      f_sample <= height_sample;
      f_sx     <= diff_x[ABS_W-1];
      f_sz     <= diff_z[ABS_W-1];
      f_absx   <= diff_x[ABS_W-1] ? ABS_W'(-diff_x) : ABS_W'(diff_x);
      f_absz   <= diff_z[ABS_W-1] ? ABS_W'(-diff_z) : ABS_W'(diff_z);
    end
  end

  // magnitude of (p - origin) * (n - 1); sign travels beside it
  always_comb begin
    front_item.mode   = f_mode;
    front_item.column = f_column;
    front_item.row    = f_row;
    front_item.sample = f_sample;
    front_item.sx     = f_sx;
    front_item.sz     = f_sz;
    front_item.magx   = MAG_W'(f_absx * cfg.gx);
    front_item.magz   = MAG_W'(f_absz * cfg.gz);
  end

endmodule

>>> sv/hti_queue.sv
// short fifo of classified items between front and back
// depends on hti_pkg
module hti_queue import hti_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  item_t         push_item,
  input  logic          pop_ready,
  output logic          head_valid,
  output item_t         head_item,
  output queue_status_t status
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t         entries [0:QUEUE_DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign status.full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign push         = push_valid && !status.full;
  assign pop          = pop_ready && !status.empty;
  assign status.push  = push;
  assign status.pop   = pop;
  assign head_valid   = !status.empty;
  assign head_item    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> sv/hti_grid_div.sv
// pipelined restoring divider, one quotient bit per stage, for one grid axis
// depends on hti_pkg
module hti_grid_div import hti_pkg::*; (
  input  logic             clk,
  input  logic             adv,
  input  logic [DIV_W-1:0] num,
  input  logic [30:0]      divisor,
  output logic [DIV_W-1:0] quot
);

  logic [30:0]      rem_q [0:DIV_W-1];
  logic [DIV_W-1:0] nq_q  [0:DIV_W-1];

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [30:0]      rem_in;
    logic [DIV_W-1:0] nq_in;
    logic [31:0]      trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
    end

    assign trial = {rem_in, nq_in[DIV_W-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k] <= ge ? 31'(trial - {1'b0, divisor}) : trial[30:0];
        nq_q[k]  <= {nq_in[DIV_W-2:0], ge};
      end
    end
  end

  assign quot = nq_q[DIV_W-1];

endmodule

>>> sv/hti_back.sv
// back part: grid dividers, corner reads, triangle blend, y scaling, result register
// depends on hti_pkg, hti_grid_div, hti_ram
module hti_back import hti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               head_valid,
  input  item_t              head_item,
  output logic               pop_ready,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] height_out
);

  typedef struct packed {
    logic       mode;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] sample;
    logic       sx;
    logic       sz;
  } side_t;

  logic adv;
  assign adv       = !result_valid || result_ready;
  assign pop_ready = adv;

  function automatic logic below(input logic [HI_W-1:0] h, input logic [8:0] n);
    below = (h[HI_W-1:9] == '0) && (h[8:0] < n);
  endfunction

  // divider stages with sideband
  logic [DIV_W-1:0] qx;
  logic [DIV_W-1:0] qz;
  logic [DIV_W-1:0] dv;
  side_t            ds [0:DIV_W-1];

  hti_grid_div u_div_x (
    .clk, .adv, .num({head_item.magx, 16'd0}), .divisor(cfg.div_x), .quot(qx)
  );
  hti_grid_div u_div_z (
    .clk, .adv, .num({head_item.magz, 16'd0}), .divisor(cfg.div_z), .quot(qz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (adv) begin
      dv <= {dv[DIV_W-2:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0] <= '{mode: head_item.mode, column: head_item.column, row: head_item.row,
                 sample: head_item.sample, sx: head_item.sx, sz: head_item.sz};
      for (int k = 1; k < DIV_W; k++) begin
        ds[k] <= ds[k-1];
      end
    end
  end

  // cell, fraction and corner selection
  side_t                tail;
  logic [HI_W-1:0]      hix;
  logic [HI_W-1:0]      hiz;
  logic signed [16:0]   dxs;
  logic signed [16:0]   dzs;
  logic signed [17:0]   dsum;
  logic                 upper;
  logic                 c0_ok, c1_ok, r0_ok, r1_ok;
  logic [7:0]           col0, col1, row0, row1;

  assign tail  = ds[DIV_W-1];
  assign hix   = qx[DIV_W-1:16];
  assign hiz   = qz[DIV_W-1:16];
  assign dxs   = tail.sx ? -$signed({1'b0, qx[15:0]}) : $signed({1'b0, qx[15:0]});
  assign dzs   = tail.sz ? -$signed({1'b0, qz[15:0]}) : $signed({1'b0, qz[15:0]});
  assign dsum  = 18'(dxs) + 18'(dzs);
  assign upper = dsum >= $signed(18'd65536);

  // a negative cell reads outside, except cell -1 whose right neighbor is 0
  assign c0_ok = (!tail.sx || hix == '0) && below(hix, cfg.cols);
  assign c1_ok = tail.sx ? (hix[HI_W-1:1] == '0) : below(hix, cfg.cols - 9'd1);
  assign r0_ok = (!tail.sz || hiz == '0) && below(hiz, cfg.rows);
  assign r1_ok = tail.sz ? (hiz[HI_W-1:1] == '0) : below(hiz, cfg.rows - 9'd1);
  assign col0  = hix[7:0];
  assign row0  = hiz[7:0];
  assign col1  = (tail.sx && hix == HI_W'(1)) ? 8'd0 : hix[7:0] + 8'd1;
  assign row1  = (tail.sz && hiz == HI_W'(1)) ? 8'd0 : hiz[7:0] + 8'd1;

  logic                c_valid;
  logic                c_mode;
  logic [STORE_AW-1:0] c_waddr;
  logic [7:0]          c_wdata;
  logic [STORE_AW-1:0] c_a10, c_a01, c_ad;
  logic                c_ok10, c_ok01, c_okd;
  logic signed [18:0]  c_ta, c_tb;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= dv[DIV_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_mode  <= tail.mode;
      c_waddr <= {tail.row, tail.column};
      c_wdata <= tail.sample;
      c_a10   <= {row0, col1};
      c_a01   <= {row1, col0};
      c_ad    <= upper ? {row1, col1} : {row0, col0};
      c_ok10  <= c1_ok && r0_ok;
      c_ok01  <= c0_ok && r1_ok;
      c_okd   <= upper ? (c1_ok && r1_ok) : (c0_ok && r0_ok);
      c_ta    <= upper ? 19'sd65536 - 19'(dzs) : 19'(dxs);
      c_tb    <= upper ? 19'sd65536 - 19'(dxs) : 19'(dzs);
    end
  end

  // three copies of the store give three corner reads per beat
  logic       we;
  logic [7:0] r10, r01, rd;
  assign we = adv && c_valid && (c_mode == MODE_LOAD);

  hti_ram #(.WIDTH(8), .DEPTH(GRID_MAX * GRID_MAX)) u_ram_10 (
    .clk, .we, .waddr(c_waddr), .wdata(c_wdata), .re(adv), .raddr(c_a10), .rdata(r10)
  );
  hti_ram #(.WIDTH(8), .DEPTH(GRID_MAX * GRID_MAX)) u_ram_01 (
    .clk, .we, .waddr(c_waddr), .wdata(c_wdata), .re(adv), .raddr(c_a01), .rdata(r01)
  );
  hti_ram #(.WIDTH(8), .DEPTH(GRID_MAX * GRID_MAX)) u_ram_d (
    .clk, .we, .waddr(c_waddr), .wdata(c_wdata), .re(adv), .raddr(c_ad), .rdata(rd)
  );

  logic               d_valid;
  logic               d_ok10, d_ok01, d_okd;
  logic signed [18:0] d_ta, d_tb;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid && (c_mode == MODE_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_ok10 <= c_ok10;
      d_ok01 <= c_ok01;
      d_okd  <= c_okd;
      d_ta   <= c_ta;
      d_tb   <= c_tb;
    end
  end

  // blend products
  logic signed [9:0]  h10, h01, hb;
  logic signed [9:0]  diff1, diff2;
  logic               e_valid;
  logic signed [31:0] e_base;
  logic signed [28:0] e_p1, e_p2;

  assign h10   = d_ok10 ? $signed({2'b0, r10}) : 10'sd0;
  assign h01   = d_ok01 ? $signed({2'b0, r01}) : 10'sd0;
  assign hb    = d_okd  ? $signed({2'b0, rd})  : 10'sd0;
  assign diff1 = h10 - hb;
  assign diff2 = h01 - hb;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_base <= $signed({22'd0, hb[9:0]}) <<< 16;
      e_p1   <= 29'(diff1 * d_ta);
      e_p2   <= 29'(diff2 * d_tb);
    end
  end

  logic               f_valid;
  logic signed [31:0] f_y;
  logic               g_valid;
  logic signed [63:0] g_prod;
  logic               h_valid;
  logic               h_neg;
  logic [CDIV_W-1:0]  h_mag;
  logic [63:0]        g_abs;

  assign g_abs = g_prod[63] ? 64'(-g_prod) : 64'(g_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      g_valid <= 1'b0;
      h_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
      g_valid <= f_valid;
      h_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_y    <= e_base + 32'(e_p1) + 32'(e_p2);
      g_prod <= 64'(f_y) * 64'(cfg.scale_y);
      h_neg  <= g_prod[63];
      h_mag  <= g_abs[62:16];
    end
  end

  // divide by 255: n = 256*h + l = 255*h + (h + l), so each stage adds the
  // high part to the quotient and the remainder loses eight bits
  logic [CDIV_W-1:0]    cn [0:CDIV_STAGES-1];
  logic [CDIV_W-1:0]    cq [0:CDIV_STAGES-1];
  logic [CDIV_W-1:0]    c_quot;
  logic [CDIV_STAGES:0] cv;
  logic [CDIV_STAGES:0] cneg;

  for (genvar k = 0; k < CDIV_STAGES; k++) begin : g_cdiv
    logic [CDIV_W-1:0] n_in;
    logic [CDIV_W-1:0] q_in;
    logic [CDIV_W-1:0] hi;

    if (k == 0) begin : g_first
      assign n_in = h_mag;
      assign q_in = '0;
    end else begin : g_next
      assign n_in = cn[k-1];
      assign q_in = cq[k-1];
    end

    assign hi = n_in >> 8;

    always_ff @(posedge clk) begin
      if (adv) begin
        cn[k] <= hi + CDIV_W'(n_in[7:0]);
        cq[k] <= q_in + hi;
      end
    end
  end

  // what is left holds at most one more 255
  always_ff @(posedge clk) begin
    if (adv) begin
      c_quot <= cq[CDIV_STAGES-1]
              + CDIV_W'(cn[CDIV_STAGES-1] >= CDIV_W'(HEIGHT_DENOM));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= '0;
    end else if (adv) begin
      cv <= {cv[CDIV_STAGES-1:0], h_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cneg <= {cneg[CDIV_STAGES-1:0], h_neg};
    end
  end

  // sign, offset and saturate
  logic signed [CDIV_W+1:0] qs;
  logic signed [CDIV_W+1:0] sum;

  assign qs  = cneg[CDIV_STAGES] ? -$signed({2'b0, c_quot})
                                 : $signed({2'b0, c_quot});
  assign sum = qs + (CDIV_W+2)'(cfg.origin_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= cv[CDIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sum > $signed((CDIV_W+2)'(32'sh7fffffff))) begin
        height_out <= 32'sh7fffffff;
      end else if (sum < -$signed((CDIV_W+2)'(33'sh080000000))) begin
        height_out <= 32'sh80000000;
      end else begin
        height_out <= sum[31:0];
      end
    end
  end

endmodule

>>> sv/heightfield_triangle_interpolator.sv
// top level: configuration registers, front stage, item queue and back pipeline
// depends on hti_pkg, hti_front, hti_queue, hti_back
//
// A grid of up to 256 x 256 8-bit height samples answers height queries at world
// points in signed Q16.16. A beat with mode 0 loads one sample at (column, row);
// a beat with mode 1 maps (query_x, query_z) into grid space, reads three corner
// samples, blends over the lower or upper triangle of the cell and returns
// height/255 * scale_y + origin_y, saturated, as one result beat. Loads give no
// result. The block takes one beat per cycle while item_ready is high and
// returns results in order; most of a query's path lies in the 57-stage
// grid-coordinate dividers, with 7 more stages for the divide by 255. Loads
// travel the same pipeline and write all three copies of the sample store at the
// stage where queries read it, so every query sees exactly the loads taken
// before it. Configuration is written through cfg_write/cfg_index/cfg_data;
// the user must write it only while idle; the block does not enforce this.
module heightfield_triangle_interpolator import hti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               mode,
  input  logic [7:0]         column,
  input  logic [7:0]         row,
  input  logic [7:0]         height_sample,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_z,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] height_out
);

  // raw configuration registers
  logic [8:0]         grid_columns;
  logic [8:0]         grid_rows;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic [30:0]        scale_x;
  logic signed [31:0] scale_y;
  logic [30:0]        scale_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= 9'd2;
      grid_rows    <= 9'd2;
      origin_x     <= '0;
      origin_y     <= '0;
      origin_z     <= '0;
      scale_x      <= 31'd65536;
      scale_y      <= 32'sd65536;
      scale_z      <= 31'd65536;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_GRID_COLUMNS: grid_columns <= cfg_data[8:0];
        REG_GRID_ROWS:    grid_rows    <= cfg_data[8:0];
        REG_ORIGIN_X:     origin_x     <= cfg_data;
        REG_ORIGIN_Y:     origin_y     <= cfg_data;
        REG_ORIGIN_Z:     origin_z     <= cfg_data;
        REG_SCALE_X:      scale_x      <= cfg_data[30:0];
        REG_SCALE_Y:      scale_y      <= cfg_data;
        REG_SCALE_Z:      scale_z      <= cfg_data[30:0];
        default:          ;
      endcase
    end
  end

  // grid sizes clamped to 2..GRID_MAX, zero extent treated as one
  cfg_t cfg;
  always_comb begin
    if (grid_columns < 9'd2) begin
      cfg.cols = 9'd2;
    end else if (grid_columns > 9'(GRID_MAX)) begin
      cfg.cols = 9'(GRID_MAX);
    end else begin
      cfg.cols = grid_columns;
    end
    if (grid_rows < 9'd2) begin
      cfg.rows = 9'd2;
    end else if (grid_rows > 9'(GRID_MAX)) begin
      cfg.rows = 9'(GRID_MAX);
    end else begin
      cfg.rows = grid_rows;
    end
    cfg.gx       = 8'(cfg.cols - 9'd1);
    cfg.gz       = 8'(cfg.rows - 9'd1);
    cfg.origin_x = origin_x;
    cfg.origin_y = origin_y;
    cfg.origin_z = origin_z;
    cfg.scale_y  = scale_y;
    cfg.div_x    = (scale_x == '0) ? 31'd1 : scale_x;
    cfg.div_z    = (scale_z == '0) ? 31'd1 : scale_z;
  end

  logic          front_valid;
  item_t         front_item;
  logic          head_valid;
  item_t         head_item;
  logic          pop_ready;
  queue_status_t qstat;

  // front: takes beats and forms the scaled offsets
  hti_front u_front (
    .clk, .rst, .cfg,
    .item_valid, .item_ready,
    .mode, .column, .row, .height_sample, .query_x, .query_z,
    .queue_full(qstat.full),
    .front_valid, .front_item
  );

  // queue lets the front keep taking beats while the back is stalled
  hti_queue u_queue (
    .clk, .rst,
    .push_valid(front_valid), .push_item(front_item),
    .pop_ready, .head_valid, .head_item,
    .status(qstat)
  );

  // back: divide, read corners, blend, scale, hold result
  hti_back u_back (
    .clk, .rst, .cfg,
    .head_valid, .head_item, .pop_ready,
    .result_valid, .result_ready, .height_out
  );

  // the front never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst) !(qstat.push && qstat.full))
    else $error("item queue overflow");

  // no result beat right after reset
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // back pressure on the input only comes from a held front item and a full queue
  assert property (@(posedge clk) disable iff (rst) !item_ready |-> (front_valid && qstat.full))
    else $error("input stalled without cause");

  // a popped item leaves the queue only when the back pipeline advances
  assert property (@(posedge clk) disable iff (rst) qstat.pop |-> (pop_ready && head_valid))
    else $error("queue popped while back is stalled");

endmodule

>>> test/tb_top.sv
// testbench for heightfield_triangle_interpolator: loads, queries, register phases
// depends on hti_pkg and the heightfield_triangle_interpolator rtl
// a built-in height predictor feeds a scoreboard that checks each result beat in order

class height_scoreboard;
  logic signed [31:0] pending[$];
  int mismatches;
  int checked;

  function void note_query(logic signed [31:0] want);
    pending.push_back(want);
  endfunction

  function void check_result(logic signed [31:0] got);
    logic signed [31:0] want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result beat with nothing pending: got %0d", got);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("height mismatch: expected %0d got %0d", want, got);
    end
  endfunction
endclass

module tb_top;
  import hti_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam longint HEIGHT_SCALE = 255 * 65536;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  cfg_reg_e           cfg_index;
  logic [31:0]        cfg_data;
  logic               item_valid;
  logic               item_ready;
  logic               mode;
  logic [7:0]         column;
  logic [7:0]         row;
  logic [7:0]         height_sample;
  logic signed [31:0] query_x;
  logic signed [31:0] query_z;
  logic               result_valid;
  logic               result_ready;
  logic signed [31:0] height_out;

  heightfield_triangle_interpolator u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready),
    .mode(mode), .column(column), .row(row), .height_sample(height_sample),
    .query_x(query_x), .query_z(query_z),
    .result_valid(result_valid), .result_ready(result_ready),
    .height_out(height_out)
  );

  // predictor copy of the registers and the sample store
  logic [8:0]         grid_cols_q;
  logic [8:0]         grid_rows_q;
  logic signed [31:0] org_x_q;
  logic signed [31:0] org_y_q;
  logic signed [31:0] org_z_q;
  logic [30:0]        ext_x_q;
  logic signed [31:0] gain_y_q;
  logic [30:0]        ext_z_q;
  logic [7:0]         height_mem [0:65535];
  bit                 loaded [0:65535];   // which samples the generator has written

  height_scoreboard sb = new();

  int  n_sent;
  int  n_accepted;
  int  n_loads;
  int  n_queries;
  int  results_seen;
  int  cycles;
  int  hold_left;
  bit  pressure_done;
  bit  calm;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run-time guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // grid dimension as the datapath uses it
  function automatic longint clamp_dim(logic [8:0] n);
    if (n < 2) return 2;
    if (n > GRID_MAX) return GRID_MAX;
    return longint'(n);
  endfunction

  // world coordinate to grid space Q16.16, truncated toward zero
  function automatic longint grid_coord(longint p, longint org, longint n, longint ext);
    longint d;
    d = (ext == 0) ? 1 : ext;
    return ((p - org) * (n - 1) * 65536) / d;
  endfunction

  function automatic longint corner_height(longint c, longint r, longint cols, longint rows);
    if (c < 0 || r < 0 || c >= cols || r >= rows) return 0;
    return longint'(height_mem[r * GRID_MAX + c]);
  endfunction

  function automatic logic signed [31:0] predict_height(logic signed [31:0] qx,
                                                       logic signed [31:0] qz);
    longint cols, rows, ix, iz, i, j, dx, dz, y, q, h00, h10, h01, h11;
    cols = clamp_dim(grid_cols_q);
    rows = clamp_dim(grid_rows_q);
    ix = grid_coord(longint'(qx), longint'(org_x_q), cols, longint'(ext_x_q));
    iz = grid_coord(longint'(qz), longint'(org_z_q), rows, longint'(ext_z_q));
    i = ix / 65536;
    j = iz / 65536;
    dx = ix - i * 65536;
    dz = iz - j * 65536;
    h10 = corner_height(i + 1, j, cols, rows);
    h01 = corner_height(i, j + 1, cols, rows);
    // lower triangle below the cell diagonal, upper triangle on and above it
    if (dx + dz < 65536) begin
      h00 = corner_height(i, j, cols, rows);
      y = h00 * 65536 + (h10 - h00) * dx + (h01 - h00) * dz;
    end else begin
      h11 = corner_height(i + 1, j + 1, cols, rows);
      y = h11 * 65536 + (h10 - h11) * (65536 - dz) + (h01 - h11) * (65536 - dx);
    end
    q = (y * longint'(gain_y_q)) / HEIGHT_SCALE + longint'(org_y_q);
    // saturate to the signed 32-bit range
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  // accepted beats update the predictor in order; result beats are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) begin
        n_accepted++;
        if (mode == MODE_QUERY) begin
          sb.note_query(predict_height(query_x, query_z));
          n_queries++;
        end else begin
          height_mem[{row, column}] = height_sample;
          n_loads++;
        end
      end
      if (result_valid && result_ready) begin
        sb.check_result(height_out);
        results_seen++;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the pipeline backs up
  always @(negedge clk) begin
    if (!pressure_done && results_seen >= 200) begin
      pressure_done = 1'b1;
      hold_left = 700;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (calm) begin
      result_ready <= 1'b1;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= 19);
    end
  end

  // one input beat; returns at the falling edge after it is taken
  task automatic send_item(input logic m, input logic [7:0] c, input logic [7:0] r,
                           input logic [7:0] h, input logic signed [31:0] qx,
                           input logic signed [31:0] qz);
    if (!calm) begin
      while ($urandom_range(0, 99) < 19) begin
        item_valid <= 1'b0;
        @(negedge clk);
      end
    end
    item_valid    <= 1'b1;
    mode          <= m;
    column        <= c;
    row           <= r;
    height_sample <= h;
    query_x       <= qx;
    query_z       <= qz;
    n_sent++;
    do @(negedge clk); while (n_accepted != n_sent);
  endtask

  task automatic send_load(input logic [7:0] c, input logic [7:0] r, input logic [7:0] h);
    loaded[{r, c}] = 1'b1;
    send_item(MODE_LOAD, c, r, h, $urandom, $urandom);
  endtask

  // a query first loads any grid corner it touches that was never written
  task automatic send_query(input logic signed [31:0] qx, input logic signed [31:0] qz);
    longint cols, rows, i, j, c, r;
    int a, b;
    cols = clamp_dim(grid_cols_q);
    rows = clamp_dim(grid_rows_q);
    i = grid_coord(longint'(qx), longint'(org_x_q), cols, longint'(ext_x_q)) / 65536;
    j = grid_coord(longint'(qz), longint'(org_z_q), rows, longint'(ext_z_q)) / 65536;
    for (a = 0; a < 2; a++) begin
      for (b = 0; b < 2; b++) begin
        c = i + a;
        r = j + b;
        if (c >= 0 && c < cols && r >= 0 && r < rows && !loaded[r * GRID_MAX + c])
          send_load(c[7:0], r[7:0], 8'($urandom));
      end
    end
    send_item(MODE_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), qx, qz);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_GRID_COLUMNS: grid_cols_q = d[8:0];
      REG_GRID_ROWS:    grid_rows_q = d[8:0];
      REG_ORIGIN_X:     org_x_q = d;
      REG_ORIGIN_Y:     org_y_q = d;
      REG_ORIGIN_Z:     org_z_q = d;
      REG_SCALE_X:      ext_x_q = d[30:0];
      REG_SCALE_Y:      gain_y_q = d;
      REG_SCALE_Z:      ext_z_q = d[30:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [31:0] cols, input logic [31:0] rows,
                            input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] oz, input logic [31:0] sx,
                            input logic [31:0] sy, input logic [31:0] sz);
    write_reg(REG_GRID_COLUMNS, cols);
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_SCALE_Z, sz);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // idle the block: all results back, then room for loads still in the pipeline
  task automatic drain;
    item_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (140) @(negedge clk);
  endtask

  // a point mostly around the grid extent, sometimes anywhere
  function automatic logic signed [31:0] pick_coord(logic signed [31:0] org, logic [30:0] ext);
    longint e, off, v;
    if ($urandom_range(0, 99) < 15) return $urandom;
    e = (ext == 0) ? 1 : longint'(ext);
    off = ((longint'($urandom_range(0, 65535)) * (e + e / 4)) >>> 16) - e / 8;
    v = longint'(org) + off;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // the count includes the corner loads that queries bring along
  task automatic random_items(input int count);
    int start;
    int lim_c, lim_r;
    start = n_sent;
    lim_c = int'(clamp_dim(grid_cols_q));
    lim_r = int'(clamp_dim(grid_rows_q));
    while (n_sent - start < count) begin
      if ($urandom_range(0, 99) < 25) begin
        if ($urandom_range(0, 9) < 8)
          send_load(8'($urandom_range(0, lim_c - 1)), 8'($urandom_range(0, lim_r - 1)),
                    8'($urandom));
        else
          send_load(8'($urandom), 8'($urandom), 8'($urandom));   // may land outside the grid
      end else begin
        send_query(pick_coord(org_x_q, ext_x_q), pick_coord(org_z_q, ext_z_q));
      end
    end
  endtask

  initial begin
    int p;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_GRID_COLUMNS;
    cfg_data = '0;
    item_valid = 1'b0;
    mode = MODE_LOAD;
    column = '0;
    row = '0;
    height_sample = '0;
    query_x = '0;
    query_z = '0;
    result_ready = 1'b0;
    calm = 1'b0;
    // reset values of the registers
    grid_cols_q = 9'd2;
    grid_rows_q = 9'd2;
    org_x_q = '0;
    org_y_q = '0;
    org_z_q = '0;
    ext_x_q = 31'd65536;
    gain_y_q = 32'sd65536;
    ext_z_q = 31'd65536;
    for (int n = 0; n < 65536; n++) begin
      height_mem[n] = '0;
      loaded[n] = 1'b0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 2x2 grid at reset settings
    send_load(8'd0, 8'd0, 8'd0);
    send_load(8'd1, 8'd0, 8'd255);
    send_load(8'd0, 8'd1, 8'd128);
    send_load(8'd1, 8'd1, 8'd77);
    send_load(8'd255, 8'd255, 8'd255);          // top of the store, outside the grid
    send_query(32'sh0, 32'sh0);
    send_query(32'sh8000, 32'sh4000);           // lower triangle
    send_query(32'shC000, 32'shC000);           // upper triangle
    send_query(32'sh8000, 32'sh8000);           // exactly on the diagonal
    send_query(32'sh10000, 32'sh10000);         // far corner, neighbors off grid
    send_query(-32'sh8000, 32'sh8000);          // negative fraction
    send_query(32'sh7FFFFFFF, 32'sh80000000);   // field extremes
    send_query(32'sh80000000, 32'sh7FFFFFFF);
    send_query(32'shFFFFFFFF, 32'sh0000FFFF);
    drain();

    for (p = 0; p < 8; p++) begin
      case (p)
        0: set_config(4, 4, 0, 0, 0, 32'h40000, 32'h10000, 32'h40000);
        // widest grid, widest extents, gain and offset pushed to saturate high
        1: set_config(256, 256, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        // undersized grid and zero extents, saturate low
        2: set_config(0, 1, 32'h00012345, 32'h80000000, 32'hFFFF0000,
                      0, 32'h80000000, 0);
        // oversized column count is clamped
        3: set_config(300, 3, 32'hFFF00000, 32'h00100000, 32'h00080000,
                      32'h00200000, 32'hFFFE0000, 1);
        default: set_config($urandom_range(2, 20), $urandom_range(2, 20), $urandom,
                            $urandom, $urandom, $urandom_range(1, 32'h7FFFFFFF),
                            $urandom, $urandom_range(1, 32'h00800000));
      endcase
      calm <= (p == 0);   // first random phase runs with no idling on either side
      random_items(240);
      drain();
    end

    $display("covered %0d loads and %0d queries over 9 register settings",
             n_loads, n_queries);
    $display("checked %0d result beats, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/hti_pkg.sv
sv/hti_ram.sv
sv/hti_front.sv
sv/hti_queue.sv
sv/hti_grid_div.sv
sv/hti_back.sv
sv/heightfield_triangle_interpolator.sv
test/tb_top.sv
